// ===== src/conv3x3_stride_pad_stream_macros.svh =====
`ifndef CONV3X3_STRIDE_PAD_STREAM_MACROS_SVH
`define CONV3X3_STRIDE_PAD_STREAM_MACROS_SVH
// assertion helpers
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== src/c3sp_pkg.sv =====
package c3sp_pkg;
  localparam int unsigned MaxWidthDef  = 1024;
  localparam int unsigned MaxHeightDef = 1024;
  localparam int unsigned PixW  = 8;
  localparam int unsigned SumW  = 28;
  localparam int unsigned IdxW  = 10;
  localparam int unsigned CfgW  = 48;
  localparam int unsigned CfgAw = 3;
  localparam logic [CfgAw-1:0] RegWidth  = 3'd0;
  localparam logic [CfgAw-1:0] RegHeight = 3'd1;
  localparam logic [CfgAw-1:0] RegStride = 3'd2;
  localparam logic [CfgAw-1:0] RegPad    = 3'd3;
  localparam logic [CfgAw-1:0] RegCoef0  = 3'd4;
  localparam logic [CfgAw-1:0] RegCoef1  = 3'd5;
  localparam logic [CfgAw-1:0] RegCoef2  = 3'd6;
  localparam logic [CfgW-1:0] CoefOneRow = 48'h0100_0100_0100;

  // one queued job: window snapshot and up to four result slots
  typedef struct packed {
    logic [8:0][PixW-1:0] win;
    logic [3:0]           vld;
    logic [3:0][1:0]      sh;     // {dy,dx}
    logic [3:0][1:0]      mask;   // {row0 zero, col0 zero}
    logic [3:0][IdxW-1:0] orow;
    logic [3:0][IdxW-1:0] ocol;
  } job_t;

  typedef struct packed {
    logic valid;
    logic stall;
  } hs_t;
endpackage

// ===== src/c3sp_ram.sv =====
module c3sp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== src/c3sp_front.sv =====
module c3sp_front import c3sp_pkg::*; #(
  parameter int unsigned MaxWidth  = MaxWidthDef,
  parameter int unsigned MaxHeight = MaxHeightDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [PixW-1:0] pixel_i,
  input  logic [10:0]     width_i,
  input  logic [10:0]     height_i,
  input  logic [2:0]      stride_i,
  input  logic            pad_i,
  output logic            job_valid_o,
  input  logic            job_stall_i,
  output job_t            job_o
);
  localparam int unsigned CW = $clog2(MaxWidth + 1);
  localparam int unsigned RW = $clog2(MaxHeight + 1);
  localparam int unsigned LW = $clog2(MaxWidth);
  localparam int unsigned AW = LW + 1;

  // stage 0: counters, line store read; stage 1: window and classify
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] w_c;
  logic [RW-1:0] h_c;
  logic [2:0]    s_c;

  always_comb begin
    w_c = (width_i < 11'd3) ? CW'(3) :
          (32'(width_i) > MaxWidth) ? CW'(MaxWidth) : CW'(width_i);
    h_c = (height_i < 11'd3) ? RW'(3) :
          (32'(height_i) > MaxHeight) ? RW'(MaxHeight) : RW'(height_i);
    s_c = (stride_i < 3'd1) ? 3'd1 : (stride_i > 3'd4) ? 3'd4 : stride_i;
  end

  logic s1_q, s1_stall;
  logic acc;
  assign in_stall_o = s1_stall;
  assign acc = in_valid_i && !in_stall_o;

  always_comb begin
    col_d = col_q; row_d = row_q;
    if (acc) begin
      if (col_q + CW'(1) >= w_c) begin
        col_d = '0;
        row_d = (row_q + RW'(1) >= h_c) ? '0 : row_q + RW'(1);
      end else col_d = col_q + CW'(1);
    end
  end

  logic in_rng;
  assign in_rng = col_q < CW'(MaxWidth);
  logic [AW-1:0] a_above, a_above2;
  assign a_above  = {~row_q[0], col_q[LW-1:0]};
  assign a_above2 = { row_q[0], col_q[LW-1:0]};
  logic [PixW-1:0] rd0, rd1;

  c3sp_ram #(.Width(PixW), .Depth(2 ** AW)) u_ram0 (
    .clk_i, .we_i(acc && in_rng), .waddr_i(a_above2), .wdata_i(pixel_i),
    .re_i(acc), .raddr_i(a_above), .rdata_o(rd0));
  c3sp_ram #(.Width(PixW), .Depth(2 ** AW)) u_ram1 (
    .clk_i, .we_i(acc && in_rng), .waddr_i(a_above2), .wdata_i(pixel_i),
    .re_i(acc), .raddr_i(a_above2), .rdata_o(rd1));

  logic [PixW-1:0] px_q;
  logic [CW-1:0]   c_q, w_q;
  logic [RW-1:0]   r_q, h_q;
  logic [2:0]      st_q;
  logic            pad_q, rng_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0; row_q <= '0; s1_q <= 1'b0;
    end else begin
      col_q <= col_d; row_q <= row_d;
      if (!s1_stall) s1_q <= acc;
    end
  end
  always_ff @(posedge clk_i) begin
    if (acc) begin
      px_q <= pixel_i; c_q <= col_q; r_q <= row_q; w_q <= w_c; h_q <= h_c;
      st_q <= s_c; pad_q <= pad_i; rng_q <= in_rng;
    end
  end

  // window shift in stage 1
  logic [8:0][PixW-1:0] win_q, win_d;
  logic [PixW-1:0] above, above2;
  assign above  = rng_q ? rd0 : '0;
  assign above2 = rng_q ? rd1 : '0;
  always_comb begin
    win_d = win_q;
    for (int k = 0; k < 3; k++) begin
      win_d[k*3+0] = win_q[k*3+1];
      win_d[k*3+1] = win_q[k*3+2];
    end
    win_d[2] = above2; win_d[5] = above; win_d[8] = px_q;
  end

  // {quotient, remainder} by stride; divide by 3 through reciprocal multiply
  function automatic logic [IdxW+2:0] divs(input logic [12:0] v, input logic [2:0] s);
    logic [IdxW+2:0] res;
    logic [25:0]     m;
    logic [12:0]     q;
    m = 26'(v) * 26'd2731;
    q = m[25:13];
    unique case (s)
      3'd1: res = {v[IdxW-1:0], 3'd0};
      3'd2: res = {v[IdxW:1], 2'd0, v[0]};
      3'd4: res = {v[IdxW+1:2], 1'b0, v[1:0]};
      default: res = {q[IdxW-1:0], 3'(v - 13'(q * 13'd3))};
    endcase
    return res;
  endfunction

  job_t job;
  logic any;
  always_comb begin
    logic [12:0] a, b;
    logic [IdxW+2:0] da, db;
    logic okr, okc;
    int n;
    job = '0;
    job.win = win_d;
    a = '0; b = '0; da = '0; db = '0; okr = 1'b0; okc = 1'b0;
    n = 0;
    if (pad_q) begin
      for (int dy = 0; dy < 2; dy++) begin
        for (int dx = 0; dx < 2; dx++) begin
          okr = (dy == 0) ? (r_q >= RW'(1)) : (r_q == h_q - RW'(1));
          okc = (dx == 0) ? (c_q >= CW'(1)) : (c_q == w_q - CW'(1));
          a = 13'(r_q) + 13'(dy) - 13'd1;
          b = 13'(c_q) + 13'(dx) - 13'd1;
          da = divs(a, st_q); db = divs(b, st_q);
          if (okr && okc && a <= 13'(h_q) - 13'd1 && b <= 13'(w_q) - 13'd1 &&
              da[2:0] == 3'd0 && db[2:0] == 3'd0) begin
            job.vld[n[1:0]] = 1'b1;
            job.sh[n[1:0]] = {1'(dy), 1'(dx)};
            job.mask[n[1:0]] = {(13'(r_q) + 13'(dy) < 13'd2), (13'(c_q) + 13'(dx) < 13'd2)};
            job.orow[n[1:0]] = da[IdxW+2:3];
            job.ocol[n[1:0]] = db[IdxW+2:3];
            n = n + 1;
          end
        end
      end
    end else if (r_q >= RW'(2) && c_q >= CW'(2)) begin
      a = 13'(r_q) - 13'd2; b = 13'(c_q) - 13'd2;
      da = divs(a, st_q); db = divs(b, st_q);
      if (a <= 13'(h_q) - 13'd3 && b <= 13'(w_q) - 13'd3 &&
          da[2:0] == 3'd0 && db[2:0] == 3'd0) begin
        job.vld[0] = 1'b1;
        job.orow[0] = da[IdxW+2:3];
        job.ocol[0] = db[IdxW+2:3];
      end
    end
  end
  assign any = |job.vld;

  // output register toward queue
  logic ov_q; job_t oj_q;
  assign s1_stall = ov_q && job_stall_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0; ov_q <= 1'b0;
    end else begin
      if (s1_q && !s1_stall) win_q <= win_d;
      if (!s1_stall) ov_q <= s1_q && any;
    end
  end
  always_ff @(posedge clk_i) begin
    if (!s1_stall && s1_q) oj_q <= job;
  end
  assign job_valid_o = ov_q;
  assign job_o = oj_q;
endmodule

// ===== src/c3sp_queue.sv =====
module c3sp_queue import c3sp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  job_t in_job_i,
  output logic out_valid_o,
  input  logic out_pop_i,
  output job_t out_job_o
);
  job_t mem_q [4];
  logic [2:0] wp_q, rp_q;
  logic [2:0] cnt;
  assign cnt = wp_q - rp_q;
  assign in_stall_o = cnt[2];
  assign out_valid_o = cnt != 3'd0;
  assign out_job_o = mem_q[rp_q[1:0]];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) wp_q <= wp_q + 3'd1;
      if (out_pop_i && out_valid_o) rp_q <= rp_q + 3'd1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) mem_q[wp_q[1:0]] <= in_job_i;
  end
endmodule

// ===== src/c3sp_back.sv =====
module c3sp_back import c3sp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_valid_i,
  output logic job_pop_o,
  input  job_t job_i,
  input  logic [2:0][CfgW-1:0] coef_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic signed [SumW-1:0] conv_sum_o,
  output logic [IdxW-1:0] out_row_o,
  output logic [IdxW-1:0] out_col_o,
  output logic last_o
);
  // issue one slot per cycle unless the output is stalled, multiply stage, add stage, output register
  logic [3:0] done_q;
  logic [3:0] pend;
  logic [1:0] sel;
  logic issue, adv;
  assign pend = job_i.vld & ~done_q;
  always_comb begin
    sel = 2'd0;
    priority if (pend[0]) sel = 2'd0;
    else if (pend[1]) sel = 2'd1;
    else if (pend[2]) sel = 2'd2;
    else sel = 2'd3;
  end
  logic [3:0] rest;
  assign rest = pend & ~(4'b1 << sel);
  logic m_v_q, a_v_q, o_v_q;
  assign adv = !(o_v_q && out_stall_i);
  assign issue = job_valid_i && adv;
  assign job_pop_o = issue && rest == 4'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= '0;
    else if (issue) done_q <= (rest == 4'd0) ? 4'd0 : done_q | (4'b1 << sel);
  end

  logic signed [8:0][24:0] prod_q;
  logic [IdxW-1:0] mr_q, mc_q, ar_q, ac_q;
  logic ml_q, al_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          logic [1:0] wi, wj;
          logic [PixW-1:0] p;
          wi = 2'(i) + {1'b0, job_i.sh[sel][1]};
          wj = 2'(j) + {1'b0, job_i.sh[sel][0]};
          if (wi > 2'd2 || wj > 2'd2 || (job_i.mask[sel][1] && wi == 2'd0) ||
              (job_i.mask[sel][0] && wj == 2'd0)) p = '0;
          else p = job_i.win[wi*3+wj];
          prod_q[i*3+j] <= $signed({1'b0, p}) * $signed(coef_i[i][16*j +: 16]);
        end
      end
      mr_q <= job_i.orow[sel]; mc_q <= job_i.ocol[sel]; ml_q <= rest == 4'd0;
      ar_q <= mr_q; ac_q <= mc_q; al_q <= ml_q;
    end
  end
  logic signed [SumW-1:0] sum_q, o_sum_q;
  logic [IdxW-1:0] or_q, oc_q;
  logic ol_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      begin
        logic signed [SumW-1:0] t;
        t = '0;
        for (int k = 0; k < 9; k++) t = t + SumW'($signed(prod_q[k]));
        sum_q <= t;
      end
      o_sum_q <= sum_q; or_q <= ar_q; oc_q <= ac_q; ol_q <= al_q;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0; a_v_q <= 1'b0; o_v_q <= 1'b0;
    end else if (adv) begin
      m_v_q <= issue; a_v_q <= m_v_q; o_v_q <= a_v_q;
    end
  end
  assign out_valid_o = o_v_q;
  assign conv_sum_o = o_sum_q;
  assign out_row_o = or_q;
  assign out_col_o = oc_q;
  assign last_o = ol_q;
endmodule

// ===== src/conv3x3_stride_pad_stream.sv =====
// channel  | valid          | stall          | payload
// pixel in | pixel_valid_i  | pixel_stall_o  | pixel_i
// result   | result_valid_o | result_stall_i | conv_sum_o, out_row_o, out_col_o, last_o
// One pixel per cycle is taken while not stalled; a pixel that completes k windows
// issues k slots to the single shared multiply/add pipeline in the back end (k up to 4).
// A result runs through stage 1, the front output register, the queue, then the back end.
// Reset clears counters, window and queue; the line store is not cleared.
// A stalled result backs up the back end, then the queue, then the pixel input.
module conv3x3_stride_pad_stream import c3sp_pkg::*; #(
  parameter int unsigned MaxWidth  = MaxWidthDef,
  parameter int unsigned MaxHeight = MaxHeightDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgAw-1:0]       cfg_addr_i,
  input  logic [CfgW-1:0]        cfg_wdata_i,
  input  logic                   pixel_valid_i,
  output logic                   pixel_stall_o,
  input  logic [PixW-1:0]        pixel_i,
  output logic                   result_valid_o,
  input  logic                   result_stall_i,
  output logic signed [SumW-1:0] conv_sum_o,
  output logic [IdxW-1:0]        out_row_o,
  output logic [IdxW-1:0]        out_col_o,
  output logic                   last_o
);
  logic [10:0] width_q, height_q;
  logic [2:0]  stride_q;
  logic        pad_q;
  logic [2:0][CfgW-1:0] coef_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 11'd1024; height_q <= 11'd1024; stride_q <= 3'd1; pad_q <= 1'b1;
      coef_q <= {CoefOneRow, CoefOneRow, CoefOneRow};
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegWidth:  width_q  <= cfg_wdata_i[10:0];
        RegHeight: height_q <= cfg_wdata_i[10:0];
        RegStride: stride_q <= cfg_wdata_i[2:0];
        RegPad:    pad_q    <= cfg_wdata_i[0];
        RegCoef0:  coef_q[0] <= cfg_wdata_i;
        RegCoef1:  coef_q[1] <= cfg_wdata_i;
        RegCoef2:  coef_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  hs_t f2q, q2b;
  job_t fjob, qjob;
  logic pop;
  c3sp_front #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight)) u_front (
    .clk_i, .rst_ni, .in_valid_i(pixel_valid_i), .in_stall_o(pixel_stall_o),
    .pixel_i, .width_i(width_q), .height_i(height_q), .stride_i(stride_q),
    .pad_i(pad_q), .job_valid_o(f2q.valid), .job_stall_i(f2q.stall), .job_o(fjob));
  c3sp_queue u_queue (
    .clk_i, .rst_ni, .in_valid_i(f2q.valid), .in_stall_o(f2q.stall), .in_job_i(fjob),
    .out_valid_o(q2b.valid), .out_pop_i(pop), .out_job_o(qjob));
  assign q2b.stall = !pop;
  c3sp_back u_back (
    .clk_i, .rst_ni, .job_valid_i(q2b.valid), .job_pop_o(pop),
    .job_i(qjob), .coef_i(coef_q), .out_valid_o(result_valid_o),
    .out_stall_i(result_stall_i), .conv_sum_o, .out_row_o, .out_col_o, .last_o);
endmodule

// ===== src/conv3x3_stride_pad_stream_chk.sv =====
`include "conv3x3_stride_pad_stream_macros.svh"
module conv3x3_stride_pad_stream_chk import c3sp_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic pixel_stall_o,
  input logic result_valid_o,
  input logic result_stall_i,
  input logic signed [SumW-1:0] conv_sum_o,
  input logic [IdxW-1:0] out_row_o,
  input logic [IdxW-1:0] out_col_o,
  input logic last_o
);
  `ASSERT_NEXT(a_hold_valid, result_valid_o && result_stall_i, result_valid_o)
  `ASSERT_NEXT(a_hold_sum, result_valid_o && result_stall_i, $stable(conv_sum_o) && $stable(last_o))
  `ASSERT_NEXT(a_hold_idx, result_valid_o && result_stall_i, $stable(out_row_o) && $stable(out_col_o))
  `ASSERT_IMPL(a_no_stall_idle, !result_valid_o && !$past(result_valid_o), !pixel_stall_o || $past(pixel_stall_o))
endmodule
bind conv3x3_stride_pad_stream conv3x3_stride_pad_stream_chk u_chk (.*);

// ===== tb/conv3x3_stride_pad_stream_tb.sv =====
module conv3x3_stride_pad_stream_tb;
  import c3sp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LineMax = 1024;
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned SettleCycles = 24;

  typedef struct packed {
    logic signed [SumW-1:0] conv_sum;
    logic [IdxW-1:0]        row;
    logic [IdxW-1:0]        col;
    logic                   last;
  } conv_res_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [CfgAw-1:0] cfg_addr;
  logic [CfgW-1:0] cfg_wdata;
  logic pix_valid;
  logic pixel_stall_o;
  logic [PixW-1:0] pix;
  logic result_valid_o;
  logic res_stall;
  logic signed [SumW-1:0] conv_sum_o;
  logic [IdxW-1:0] out_row_o;
  logic [IdxW-1:0] out_col_o;
  logic last_o;

  conv3x3_stride_pad_stream u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .pixel_valid_i (pix_valid),
    .pixel_stall_o (pixel_stall_o),
    .pixel_i       (pix),
    .result_valid_o(result_valid_o),
    .result_stall_i(res_stall),
    .conv_sum_o    (conv_sum_o),
    .out_row_o     (out_row_o),
    .out_col_o     (out_col_o),
    .last_o        (last_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // predictor state
  logic [PixW-1:0] line_mem [0:2*LineMax-1];
  logic [PixW-1:0] win [3][3];
  int unsigned cnt_col, cnt_row;
  int unsigned cfg_width, cfg_height, cfg_stride, cfg_pad;
  logic [CfgW-1:0] cfg_coef [3];

  conv_res_t conv_q[$];
  logic [PixW-1:0] pixel_q[$];
  int unsigned err_cnt;
  bit burst;
  bit press_req;
  int unsigned gap_cnt;
  int unsigned hold_cnt;
  int unsigned press_cnt;
  longint unsigned cycles;

  function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint win_sum(int unsigned r, int unsigned c, int unsigned dy,
                                     int unsigned dx);
    longint acc;
    int unsigned wi, wj;
    acc = 0;
    for (int unsigned i = 0; i < 3; i++) begin
      for (int unsigned j = 0; j < 3; j++) begin
        wi = i + dy;
        wj = j + dx;
        if (wi <= 2 && wj <= 2 && r + wi >= 2 && c + wj >= 2)
          acc += longint'(win[wi][wj]) * longint'($signed(cfg_coef[i][16*j +: 16]));
      end
    end
    return acc;
  endfunction

  function automatic void predict_pixel(logic [PixW-1:0] px);
    int unsigned w, h, s, r, c, a, b;
    logic [PixW-1:0] above, above2;
    conv_res_t res [$];
    conv_res_t item;
    longint acc;
    w = clampu(cfg_width, 3, LineMax);
    h = clampu(cfg_height, 3, LineMax);
    s = clampu(cfg_stride, 1, 4);
    r = cnt_row;
    c = cnt_col;
    above = '0;
    above2 = '0;
    if (c < LineMax) begin
      above = line_mem[((r & 1) ^ 1) * LineMax + c];
      above2 = line_mem[(r & 1) * LineMax + c];
      line_mem[(r & 1) * LineMax + c] = px;
    end
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = above2;
    win[1][2] = above;
    win[2][2] = px;
    if (cfg_pad != 0) begin
      for (int unsigned dy = 0; dy < 2; dy++) begin
        if (dy == 0 && r < 1) continue;
        if (dy == 1 && r != h - 1) continue;
        a = r + dy - 1;
        if (a > h - 1 || a % s != 0) continue;
        for (int unsigned dx = 0; dx < 2; dx++) begin
          if (dx == 0 && c < 1) continue;
          if (dx == 1 && c != w - 1) continue;
          b = c + dx - 1;
          if (b > w - 1 || b % s != 0) continue;
          acc = win_sum(r, c, dy, dx);
          item.conv_sum = acc[SumW-1:0];
          item.row = IdxW'(a / s);
          item.col = IdxW'(b / s);
          item.last = 1'b0;
          res.push_back(item);
        end
      end
    end else if (r >= 2 && c >= 2) begin
      a = r - 2;
      b = c - 2;
      if (a <= h - 3 && b <= w - 3 && a % s == 0 && b % s == 0) begin
        acc = win_sum(r, c, 0, 0);
        item.conv_sum = acc[SumW-1:0];
        item.row = IdxW'(a / s);
        item.col = IdxW'(b / s);
        item.last = 1'b0;
        res.push_back(item);
      end
    end
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    foreach (res[k]) conv_q.push_back(res[k]);
    if (c + 1 >= w) begin
      cnt_col = 0;
      cnt_row = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      cnt_col = c + 1;
    end
  endfunction

  // pixel driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_valid <= 1'b0;
      pix <= '0;
      gap_cnt = 0;
    end else if (!pix_valid || !pixel_stall_o) begin
      if (gap_cnt > 0) begin
        pix_valid <= 1'b0;
        gap_cnt = gap_cnt - 1;
      end else if (pixel_q.size() > 0) begin
        pix_valid <= 1'b1;
        pix <= pixel_q.pop_front();
        gap_cnt = burst ? 0 : $urandom_range(0, 12);
      end else begin
        pix_valid <= 1'b0;
      end
    end
  end

  // prediction on each pixel transfer
  always @(posedge clk_i) begin
    if (rst_ni && pix_valid && !pixel_stall_o) predict_pixel(pix);
  end

  // result monitor and receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    conv_res_t want;
    if (!rst_ni) begin
      res_stall <= 1'b0;
      hold_cnt = 0;
      press_cnt = 0;
    end else begin
      if (result_valid_o && !res_stall) begin
        if (conv_q.size() == 0) begin
          $error("unexpected result row %0d col %0d", out_row_o, out_col_o);
          err_cnt++;
        end else begin
          want = conv_q.pop_front();
          if (conv_sum_o !== want.conv_sum) begin
            $error("conv_sum: expected %0d, got %0d", want.conv_sum, conv_sum_o);
            err_cnt++;
          end
          if (out_row_o !== want.row) begin
            $error("out_row: expected %0d, got %0d", want.row, out_row_o);
            err_cnt++;
          end
          if (out_col_o !== want.col) begin
            $error("out_col: expected %0d, got %0d", want.col, out_col_o);
            err_cnt++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last_o);
            err_cnt++;
          end
        end
        hold_cnt = burst ? 0 : $urandom_range(0, 12);
      end
      if (press_req) begin
        press_req = 1'b0;
        press_cnt = 400;
      end
      if (press_cnt > 0) begin
        press_cnt = press_cnt - 1;
        res_stall <= 1'b1;
      end else if (hold_cnt > 0) begin
        hold_cnt = hold_cnt - 1;
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("conv3x3_stride_pad_stream_tb failed");
      $finish;
    end
  end

  task automatic cfg_write(logic [CfgAw-1:0] idx, logic [CfgW-1:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      RegWidth:  cfg_width = 32'(val[10:0]);
      RegHeight: cfg_height = 32'(val[10:0]);
      RegStride: cfg_stride = 32'(val[2:0]);
      RegPad:    cfg_pad = 32'(val[0]);
      RegCoef0:  cfg_coef[0] = val;
      RegCoef1:  cfg_coef[1] = val;
      RegCoef2:  cfg_coef[2] = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CfgW-1:0] rand_coef();
    logic [CfgW-1:0] v;
    v = CfgW'({$urandom, $urandom});
    case ($urandom_range(0, 5))
      0: v = 48'h7FFF_7FFF_7FFF;
      1: v = 48'h8000_8000_8000;
      default: ;
    endcase
    return v;
  endfunction

  // mode 0: random, 1: all 255, 2: alternating 0/255
  task automatic run_image(int unsigned w, int unsigned h, int unsigned s, int unsigned pd,
                           logic [CfgW-1:0] c0, logic [CfgW-1:0] c1, logic [CfgW-1:0] c2,
                           int mode, bit fast);
    int unsigned n;
    cfg_write(RegWidth, CfgW'(w));
    cfg_write(RegHeight, CfgW'(h));
    cfg_write(RegStride, CfgW'(s));
    cfg_write(RegPad, CfgW'(pd));
    cfg_write(RegCoef0, c0);
    cfg_write(RegCoef1, c1);
    cfg_write(RegCoef2, c2);
    burst = fast;
    n = clampu(w, 3, LineMax) * clampu(h, 3, LineMax);
    for (int unsigned k = 0; k < n; k++) begin
      case (mode)
        1: pixel_q.push_back(8'hFF);
        2: pixel_q.push_back(k[0] ? 8'h00 : 8'hFF);
        default: begin
          case ($urandom_range(0, 7))
            0: pixel_q.push_back(8'h00);
            1: pixel_q.push_back(8'hFF);
            default: pixel_q.push_back(PixW'($urandom_range(0, 255)));
          endcase
        end
      endcase
    end
    do @(posedge clk_i);
    while (pixel_q.size() > 0 || pix_valid || conv_q.size() > 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    int unsigned rand_items, w, h;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    res_stall = 1'b0;
    err_cnt = 0;
    burst = 1'b0;
    press_req = 1'b0;
    cycles = 0;
    cnt_col = 0;
    cnt_row = 0;
    cfg_width = 1024;
    cfg_height = 1024;
    cfg_stride = 1;
    cfg_pad = 1;
    for (int k = 0; k < 3; k++) cfg_coef[k] = CoefOneRow;
    for (int k = 0; k < 3; k++) for (int m = 0; m < 3; m++) win[k][m] = '0;
    for (int k = 0; k < 2 * LineMax; k++) line_mem[k] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: max positive and min negative sums, clamped registers
    run_image(3, 3, 1, 1, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 1, 0);
    run_image(3, 3, 1, 0, 48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000, 1, 0);
    run_image(0, 2, 0, 1, 48'h0000_FFFF_0001, 48'hFFFF_0000_7FFF, 48'h8000_0100_0000, 2, 0);

    // random part, long receiver hold-off on the first image
    rand_items = 0;
    while (rand_items < 100) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
      h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
      if (rand_items == 0) begin
        press_req = 1'b1;
        w = 8;
        h = 6;
      end
      run_image(w, h, $urandom_range(0, 7), $urandom_range(0, 1),
                rand_coef(), rand_coef(), rand_coef(), 0, (rand_items == 0) || $urandom_range(0, 3) == 0);
      rand_items += clampu(w, 3, LineMax) * clampu(h, 3, LineMax);
    end

    if (err_cnt == 0 && conv_q.size() == 0) begin
      $display("conv3x3_stride_pad_stream_tb passed");
    end else begin
      $display("conv3x3_stride_pad_stream_tb failed");
    end
    $finish;
  end

endmodule
